FILE: design/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// shared widths, register indexes, codes and sequencer states of the
// pid controller with clamped integral
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidc_pkg;

    // field widths
    localparam int DATA_W    = 32;  // q16.16 samples, gains and limits
    localparam int DT_W      = 31;  // time step, unsigned q15.16
    localparam int ACC_W     = 48;  // integral accumulator, q32.16
    localparam int CFG_IDX_W = 3;   // register index
    localparam int ICLAMP_W  = 2;   // integral clamp code

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_TERM_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_TERM_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MIN    = 3'd6;

    // integral clamp codes
    localparam logic [ICLAMP_W-1:0] ICLAMP_NONE = 2'd0;
    localparam logic [ICLAMP_W-1:0] ICLAMP_MAX  = 2'd1;
    localparam logic [ICLAMP_W-1:0] ICLAMP_MIN  = 2'd2;

    // saturation bounds
    localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_DT,
        ST_ACC,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_ISUM,
        ST_ICLAMP,
        ST_WB_LOAD,
        ST_WB_DIV,
        ST_WB_DONE,
        ST_D_LOAD,
        ST_D_DIV,
        ST_D_DONE,
        ST_MUL_D,
        ST_SUM,
        ST_DONE
    } state_t;

    // operand pair of the shared multiplier
    typedef enum logic [2:0] {
        MUL_SEL_PROP,
        MUL_SEL_DT,
        MUL_SEL_ILO,
        MUL_SEL_IHI,
        MUL_SEL_DERIV
    } mul_sel_t;

endpackage

FILE: design/pidc_intf.sv
// ----------------------------------------------------------------------------
// pidc channel interfaces
// valid/ready channels for samples, results and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pidc_in_if
    import pidc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] error_sample;
    logic [DT_W-1:0]          time_step;

    modport source (output valid, error_sample, time_step, input ready);
    modport sink   (input valid, error_sample, time_step, output ready);
endinterface

interface pidc_out_if
    import pidc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] command;
    logic                     rejected;
    logic [ICLAMP_W-1:0]      integ_clamp;
    logic                     command_clamped;

    modport source (output valid, command, rejected, integ_clamp, command_clamped,
                    input ready);
    modport sink   (input valid, command, rejected, integ_clamp, command_clamped,
                    output ready);
endinterface

interface pidc_cfg_if
    import pidc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/pid_controller_clamped_integral.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_integral
// a sample is taken only while idle, so the next waits until the previous
//   result is loaded into the result slot; a zero step skips to the result
// pace set by the bit-serial divider (49 steps per division) and the shared
//   32x32 multiplier; a written-back clamped integral adds a second division
// reset: rst_n clears gains, limits, integral, last error and the result slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_controller_clamped_integral
    import pidc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pidc_in_if.sink     sample,
    pidc_out_if.source  result,
    pidc_cfg_if.sink    cfg
);

    // internal widths
    localparam int PROD_W   = 2 * DATA_W;      // full product of the multiplier
    localparam int LOPROD_W = 57;              // 24-bit unsigned x 32-bit signed
    localparam int HALF_W   = ACC_W / 2;       // split of the accumulator
    localparam int FRAC_W   = 16;              // q16.16 fraction bits
    localparam int DIV_N_W  = 49;              // dividend magnitude width
    localparam int WIDE_W   = 50;              // signed quotient / command sum
    localparam int CNT_W    = 6;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_N_W - 1);

    // ------------------------------------------------------------------------
    // saturation helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] x);
        logic [WIDE_W-ACC_W:0] upper;
        upper = x[WIDE_W-1:ACC_W-1];
        if ((&upper) || !(|upper))
            return x[ACC_W-1:0];
        else
            return x[WIDE_W-1] ? ACC_MIN : ACC_MAX;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] x);
        logic [WIDE_W-DATA_W:0] upper;
        upper = x[WIDE_W-1:DATA_W-1];
        if ((&upper) || !(|upper))
            return x[DATA_W-1:0];
        else
            return x[WIDE_W-1] ? S32_MIN : S32_MAX;
    endfunction

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    state_t state_reg, state_next;

    // configuration
    logic signed [DATA_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic signed [DATA_W-1:0] integ_term_max_reg, integ_term_min_reg;
    logic signed [DATA_W-1:0] command_max_reg, command_min_reg;

    // controller state kept across samples
    logic signed [ACC_W-1:0]  accum_reg, accum_next;
    logic signed [DATA_W-1:0] last_err_reg;

    // per-sample working registers
    logic signed [DATA_W-1:0]   err_reg;
    logic [DT_W-1:0]            dt_reg;
    logic                       rej_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    pterm_reg;
    logic signed [LOPROD_W-1:0] lo_prod_reg;
    logic signed [PROD_W-1:0]   iterm_full_reg;
    logic signed [DATA_W-1:0]   iterm_reg, iterm_next;
    logic [ICLAMP_W-1:0]        iclamp_reg, iclamp_next;
    logic signed [DATA_W-1:0]   derr_reg;
    logic signed [WIDE_W-1:0]   cmd_sum_reg;

    // divider
    logic [DATA_W-1:0]  div_rem_reg, div_rem_next;
    logic [DIV_N_W-1:0] div_quo_reg, div_quo_next;
    logic [DATA_W-1:0]  div_den_reg, div_den_next;
    logic               div_neg_reg, div_neg_next;
    logic [CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    // result slot
    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   command_reg, command_next;
    logic                       rejected_reg;
    logic [ICLAMP_W-1:0]        integ_clamp_reg;
    logic                       command_clamped_reg, command_clamped_next;

    // ------------------------------------------------------------------------
    // sequencer decodes
    // ------------------------------------------------------------------------
    logic     sample_ready;
    mul_sel_t mul_sel;
    logic     pterm_load, accum_step_load, lo_load, iterm_full_load, iterm_load;
    logic     div_load_wb, div_load_d, div_step, accum_wb_load, derr_load;
    logic     sum_load, result_load;
    logic     sample_fire, out_free, wb_needed, div_last;

    assign sample_fire = sample.valid && sample_ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign div_last    = (div_cnt_reg == DIV_LAST);

    // write-back of the integral only when clamped and the gain can divide
    assign wb_needed = (iclamp_next != ICLAMP_NONE) && (integ_gain_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_fire)
                    state_next = (sample.time_step == '0) ? ST_DONE : ST_MUL_P;
            end
            ST_MUL_P:   state_next = ST_MUL_DT;
            ST_MUL_DT:  state_next = ST_ACC;
            ST_ACC:     state_next = ST_MUL_ILO;
            ST_MUL_ILO: state_next = ST_MUL_IHI;
            ST_MUL_IHI: state_next = ST_ISUM;
            ST_ISUM:    state_next = ST_ICLAMP;
            ST_ICLAMP:  state_next = wb_needed ? ST_WB_LOAD : ST_D_LOAD;
            ST_WB_LOAD: state_next = ST_WB_DIV;
            ST_WB_DIV:
            begin
                if (div_last)
                    state_next = ST_WB_DONE;
            end
            ST_WB_DONE: state_next = ST_D_LOAD;
            ST_D_LOAD:  state_next = ST_D_DIV;
            ST_D_DIV:
            begin
                if (div_last)
                    state_next = ST_D_DONE;
            end
            ST_D_DONE:  state_next = ST_MUL_D;
            ST_MUL_D:   state_next = ST_SUM;
            ST_SUM:     state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // state decodes
    always_comb
    begin
        sample_ready    = 1'b0;
        mul_sel         = MUL_SEL_PROP;
        pterm_load      = 1'b0;
        accum_step_load = 1'b0;
        lo_load         = 1'b0;
        iterm_full_load = 1'b0;
        iterm_load      = 1'b0;
        div_load_wb     = 1'b0;
        div_load_d      = 1'b0;
        div_step        = 1'b0;
        accum_wb_load   = 1'b0;
        derr_load       = 1'b0;
        sum_load        = 1'b0;
        result_load     = 1'b0;
        case (state_reg)
            ST_IDLE:    sample_ready = 1'b1;
            ST_MUL_P:   mul_sel = MUL_SEL_PROP;
            ST_MUL_DT:
            begin
                mul_sel    = MUL_SEL_DT;
                pterm_load = 1'b1;
            end
            ST_ACC:     accum_step_load = 1'b1;
            ST_MUL_ILO: mul_sel = MUL_SEL_ILO;
            ST_MUL_IHI:
            begin
                mul_sel = MUL_SEL_IHI;
                lo_load = 1'b1;
            end
            ST_ISUM:    iterm_full_load = 1'b1;
            ST_ICLAMP:  iterm_load = 1'b1;
            ST_WB_LOAD: div_load_wb = 1'b1;
            ST_WB_DIV:  div_step = 1'b1;
            ST_WB_DONE: accum_wb_load = 1'b1;
            ST_D_LOAD:  div_load_d = 1'b1;
            ST_D_DIV:   div_step = 1'b1;
            ST_D_DONE:  derr_load = 1'b1;
            ST_MUL_D:   mul_sel = MUL_SEL_DERIV;
            ST_SUM:     sum_load = 1'b1;
            ST_DONE:    result_load = out_free;
            default:    sample_ready = 1'b0;
        endcase
    end

    assign sample.ready = sample_ready;
    assign cfg.ready    = 1'b1;

    // ------------------------------------------------------------------------
    // shared multiplier, registered every cycle; each product is consumed
    // in the state right after the one that selected its operands
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb
    begin
        case (mul_sel)
            MUL_SEL_PROP:
            begin
                mul_a = prop_gain_reg;
                mul_b = err_reg;
            end
            MUL_SEL_DT:
            begin
                mul_a = {1'b0, dt_reg};
                mul_b = err_reg;
            end
            // low half of the accumulator is an unsigned digit
            MUL_SEL_ILO:
            begin
                mul_a = {{(DATA_W-HALF_W){1'b0}}, accum_reg[HALF_W-1:0]};
                mul_b = integ_gain_reg;
            end
            // high half carries the sign
            MUL_SEL_IHI:
            begin
                mul_a = {{(DATA_W-HALF_W){accum_reg[ACC_W-1]}}, accum_reg[ACC_W-1:HALF_W]};
                mul_b = integ_gain_reg;
            end
            MUL_SEL_DERIV:
            begin
                mul_a = deriv_gain_reg;
                mul_b = derr_reg;
            end
            default:
            begin
                mul_a = prop_gain_reg;
                mul_b = err_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // product shifted to q.16 with floor rounding (arithmetic shift)
    logic signed [PROD_W-1:0] prod_shr;
    assign prod_shr = prod_reg >>> FRAC_W;

    // ------------------------------------------------------------------------
    // integral step: accum + floor(dt*err), saturated to 48 bits
    // ------------------------------------------------------------------------
    logic signed [WIDE_W-1:0] acc_step_sum;
    assign acc_step_sum = WIDE_W'(accum_reg) + WIDE_W'($signed(prod_shr[ACC_W-1:0]));

    // ------------------------------------------------------------------------
    // integral term: floor(accum*gain/2^16) = (hi*gain << 8) + floor(lo*gain/2^16)
    // ------------------------------------------------------------------------
    logic signed [PROD_W-1:0] iterm_sum;
    assign iterm_sum = (prod_reg <<< (HALF_W - FRAC_W))
                     + PROD_W'(lo_prod_reg >>> FRAC_W);

    // clamp against the term limits, max test first
    always_comb
    begin
        if (iterm_full_reg > PROD_W'(integ_term_max_reg))
        begin
            iterm_next  = integ_term_max_reg;
            iclamp_next = ICLAMP_MAX;
        end
        else if (iterm_full_reg < PROD_W'(integ_term_min_reg))
        begin
            iterm_next  = integ_term_min_reg;
            iclamp_next = ICLAMP_MIN;
        end
        else
        begin
            iterm_next  = iterm_full_reg[DATA_W-1:0];
            iclamp_next = ICLAMP_NONE;
        end
    end

    // ------------------------------------------------------------------------
    // bit-serial restoring divider on magnitudes, one quotient bit a cycle
    // ------------------------------------------------------------------------
    logic signed [DIV_N_W-1:0] wb_num, d_num;
    logic signed [DATA_W:0]    err_diff;
    logic [DATA_W:0]           rem_shift, rem_sub;
    logic                      rem_ge;
    logic signed [WIDE_W-1:0]  quo_signed;

    // write-back dividend: clamped term << 16
    assign wb_num   = {iterm_reg[DATA_W-1], iterm_reg, {FRAC_W{1'b0}}};
    // derivative dividend: (err - last) << 16
    assign err_diff = (DATA_W+1)'(err_reg) - (DATA_W+1)'(last_err_reg);
    assign d_num    = {err_diff, {FRAC_W{1'b0}}};

    assign rem_shift = {div_rem_reg, div_quo_reg[DIV_N_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_den_reg};
    assign rem_ge    = (rem_shift >= {1'b0, div_den_reg});

    // quotient sign applied afterwards gives truncation toward zero
    assign quo_signed = div_neg_reg ? -$signed({1'b0, div_quo_reg})
                                    :  $signed({1'b0, div_quo_reg});

    always_comb
    begin
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;
        div_neg_next = div_neg_reg;
        div_cnt_next = div_cnt_reg;
        if (div_load_wb)
        begin
            div_rem_next = '0;
            div_quo_next = wb_num[DIV_N_W-1] ? DIV_N_W'(-wb_num) : DIV_N_W'(wb_num);
            div_den_next = integ_gain_reg[DATA_W-1] ? DATA_W'(-integ_gain_reg)
                                                   : DATA_W'(integ_gain_reg);
            div_neg_next = iterm_reg[DATA_W-1] ^ integ_gain_reg[DATA_W-1];
            div_cnt_next = '0;
        end
        else if (div_load_d)
        begin
            div_rem_next = '0;
            div_quo_next = d_num[DIV_N_W-1] ? DIV_N_W'(-d_num) : DIV_N_W'(d_num);
            div_den_next = {1'b0, dt_reg};
            div_neg_next = err_diff[DATA_W];
            div_cnt_next = '0;
        end
        else if (div_step)
        begin
            div_rem_next = rem_ge ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            div_quo_next = {div_quo_reg[DIV_N_W-2:0], rem_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // integral register: step add, then optional write-back limit/gain
    // ------------------------------------------------------------------------
    always_comb
    begin
        accum_next = accum_reg;
        if (accum_step_load)
            accum_next = sat_acc(acc_step_sum);
        else if (accum_wb_load)
            accum_next = sat_acc(quo_signed);
    end

    // ------------------------------------------------------------------------
    // command limits: max first, then min; zero limit disabled, then saturate
    // ------------------------------------------------------------------------
    logic signed [WIDE_W-1:0] cmd_after_max, cmd_after_min;
    logic                     hit_max, hit_min;

    assign hit_max       = (command_max_reg != '0) && (cmd_sum_reg > WIDE_W'(command_max_reg));
    assign cmd_after_max = hit_max ? WIDE_W'(command_max_reg) : cmd_sum_reg;
    assign hit_min       = (command_min_reg != '0) && (cmd_after_max < WIDE_W'(command_min_reg));
    assign cmd_after_min = hit_min ? WIDE_W'(command_min_reg) : cmd_after_max;

    always_comb
    begin
        if (rej_reg)
        begin
            command_next         = '0;
            command_clamped_next = 1'b0;
        end
        else
        begin
            command_next         = sat_s32(cmd_after_min);
            command_clamped_next = hit_max || hit_min;
        end
    end

    // ------------------------------------------------------------------------
    // control and state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            prop_gain_reg      <= '0;
            integ_gain_reg     <= '0;
            deriv_gain_reg     <= '0;
            integ_term_max_reg <= '0;
            integ_term_min_reg <= '0;
            command_max_reg    <= '0;
            command_min_reg    <= '0;
            accum_reg          <= '0;
            last_err_reg       <= '0;
            div_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            accum_reg   <= accum_next;
            div_cnt_reg <= div_cnt_next;

            // last error moves on when the derivative division starts
            if (div_load_d)
                last_err_reg <= err_reg;

            // register write transaction, unknown indexes ignored
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_PROP_GAIN:      prop_gain_reg      <= cfg.data;
                    REG_INTEG_GAIN:     integ_gain_reg     <= cfg.data;
                    REG_DERIV_GAIN:     deriv_gain_reg     <= cfg.data;
                    REG_INTEG_TERM_MAX: integ_term_max_reg <= cfg.data;
                    REG_INTEG_TERM_MIN: integ_term_min_reg <= cfg.data;
                    REG_COMMAND_MAX:    command_max_reg    <= cfg.data;
                    REG_COMMAND_MIN:    command_min_reg    <= cfg.data;
                    default:            ;
                endcase
            end

            // result slot: filled when free, emptied by a result transaction
            if (result_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_p;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        div_neg_reg <= div_neg_next;

        if (sample_fire)
        begin
            err_reg <= sample.error_sample;
            dt_reg  <= sample.time_step;
            rej_reg <= (sample.time_step == '0);
        end
        if (pterm_load)
            pterm_reg <= prod_shr[ACC_W-1:0];
        if (lo_load)
            lo_prod_reg <= prod_reg[LOPROD_W-1:0];
        if (iterm_full_load)
            iterm_full_reg <= iterm_sum;
        if (iterm_load)
        begin
            iterm_reg  <= iterm_next;
            iclamp_reg <= iclamp_next;
        end
        if (derr_load)
            derr_reg <= sat_s32(quo_signed);
        // p + i + d at full width
        if (sum_load)
            cmd_sum_reg <= WIDE_W'(pterm_reg) + WIDE_W'(iterm_reg)
                         + WIDE_W'($signed(prod_shr[ACC_W-1:0]));
        if (result_load)
        begin
            command_reg         <= command_next;
            rejected_reg        <= rej_reg;
            integ_clamp_reg     <= rej_reg ? ICLAMP_NONE : iclamp_reg;
            command_clamped_reg <= command_clamped_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.command         = command_reg;
    assign result.rejected        = rejected_reg;
    assign result.integ_clamp     = integ_clamp_reg;
    assign result.command_clamped = command_clamped_reg;

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the pid controller with clamped integral: samples
// are queued, driven with random gaps, and every result transaction is
// checked field by field against an in-bench q16.16 pid predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import pidc_pkg::*;

    localparam int HALF_PERIOD       = 10;
    localparam int RESET_CYCLES      = 8;
    localparam int RANDOM_BLOCKS     = 6;
    localparam int BLOCK_ITEMS       = 125;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES      = 120;  // above the clamped-path latency

    // index with no register behind it, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] error_sample;
        logic [DT_W-1:0]          time_step;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] command;
        logic                     rejected;
        logic [ICLAMP_W-1:0]      integ_clamp;
        logic                     command_clamped;
    } command_result_t;

    logic clk = 1'b0;
    logic rst_n;

    pidc_in_if  sample_if ();
    pidc_out_if result_if ();
    pidc_cfg_if cfg_if ();

    pid_controller_clamped_integral dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor state: register file and controller memory, reset values
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] prop_gain      = '0;
    logic signed [DATA_W-1:0] integ_gain     = '0;
    logic signed [DATA_W-1:0] deriv_gain     = '0;
    logic signed [DATA_W-1:0] integ_term_max = '0;
    logic signed [DATA_W-1:0] integ_term_min = '0;
    logic signed [DATA_W-1:0] command_max    = '0;
    logic signed [DATA_W-1:0] command_min    = '0;
    longint                   integ_acc      = 0;  // q32.16, held within 48 bits
    longint                   prev_error     = 0;

    sample_t         pending_samples[$];   // waiting to be offered
    command_result_t expected_results[$];  // one per accepted sample
    sample_t         offer;

    int error_count = 0;
    int tx_idle_pct = 24;
    int rx_idle_pct = 51;
    logic stall_request = 1'b0;  // raised once by the main sequence
    logic hold_results;          // long receiver stall in progress

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [DATA_W-1:0] val);
        case (idx)
            REG_PROP_GAIN:      prop_gain      = val;
            REG_INTEG_GAIN:     integ_gain     = val;
            REG_DERIV_GAIN:     deriv_gain     = val;
            REG_INTEG_TERM_MAX: integ_term_max = val;
            REG_INTEG_TERM_MIN: integ_term_min = val;
            REG_COMMAND_MAX:    command_max    = val;
            REG_COMMAND_MIN:    command_min    = val;
            default: ;  // unmapped index, write dropped
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // one control step: p + clamped i + d, then the command limits
    // ------------------------------------------------------------------------
    function automatic command_result_t compute_command(input logic signed [DATA_W-1:0] err,
                                                        input logic [DT_W-1:0] dt);
        command_result_t   res;
        longint            e, dtl, gp, gi, gd, i_hi, i_lo, c_hi, c_lo;
        longint            p_term, i_term, d_term, slope, total;
        logic signed [95:0] acc_w, gain_w, prod_w;

        res.command         = '0;
        res.rejected        = 1'b0;
        res.integ_clamp     = ICLAMP_NONE;
        res.command_clamped = 1'b0;

        // zero time step: sample dropped, state untouched
        if (dt == '0)
        begin
            res.rejected = 1'b1;
            return res;
        end

        e    = longint'(err);
        dtl  = longint'(dt);
        gp   = longint'(prop_gain);
        gi   = longint'(integ_gain);
        gd   = longint'(deriv_gain);
        i_hi = longint'(integ_term_max);
        i_lo = longint'(integ_term_min);
        c_hi = longint'(command_max);
        c_lo = longint'(command_min);

        // products are exact, >>> by 16 rounds toward minus infinity
        p_term    = (gp * e) >>> 16;
        integ_acc = clip(integ_acc + ((dtl * e) >>> 16), longint'(ACC_MIN),
                         longint'(ACC_MAX));

        // accumulator times gain needs more than 64 bits before the shift
        acc_w  = 96'(integ_acc);
        gain_w = 96'(gi);
        prod_w = (acc_w * gain_w) >>> 16;
        i_term = prod_w[63:0];

        // max test first, so with crossed limits a term above the max ends on the max
        if (i_term > i_hi)
        begin
            i_term          = i_hi;
            res.integ_clamp = ICLAMP_MAX;
        end
        else if (i_term < i_lo)
        begin
            i_term          = i_lo;
            res.integ_clamp = ICLAMP_MIN;
        end
        // anti-windup write-back, skipped for a zero gain
        if (res.integ_clamp != ICLAMP_NONE && gi != 0)
            integ_acc = clip((i_term * 65536) / gi, longint'(ACC_MIN), longint'(ACC_MAX));

        slope      = clip(((e - prev_error) * 65536) / dtl, longint'(S32_MIN),
                          longint'(S32_MAX));
        prev_error = e;
        d_term     = (gd * slope) >>> 16;

        // a zero limit is disabled, min applied last
        total = p_term + i_term + d_term;
        if (c_hi != 0 && total > c_hi)
        begin
            total               = c_hi;
            res.command_clamped = 1'b1;
        end
        if (c_lo != 0 && total < c_lo)
        begin
            total               = c_lo;
            res.command_clamped = 1'b1;
        end
        res.command = DATA_W'(clip(total, longint'(S32_MIN), longint'(S32_MAX)));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers queued samples, predicts on every accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_if.valid        <= 1'b0;
            sample_if.error_sample <= '0;
            sample_if.time_step    <= '0;
        end
        else
        begin
            if (sample_if.valid && sample_if.ready)
                expected_results.push_back(
                    compute_command(sample_if.error_sample, sample_if.time_step));
            // a pending offer stays up until taken
            if (!sample_if.valid || sample_if.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    offer                   = pending_samples.pop_front();
                    sample_if.valid        <= 1'b1;
                    sample_if.error_sample <= offer.error_sample;
                    sample_if.time_step    <= offer.time_step;
                end
                else
                    sample_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random backpressure, checks each result transaction
    // ------------------------------------------------------------------------
    function automatic void report_field(input string name, input longint want,
                                         input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_result();
        command_result_t want;

        if (expected_results.size() == 0)
        begin
            $error("result transaction with nothing outstanding: command %0d",
                   result_if.command);
            error_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            report_field("command", longint'(want.command), longint'(result_if.command));
            report_field("rejected", longint'(want.rejected),
                         longint'(result_if.rejected));
            report_field("integ_clamp", longint'(want.integ_clamp),
                         longint'(result_if.integ_clamp));
            report_field("command_clamped", longint'(want.command_clamped),
                         longint'(result_if.command_clamped));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            if (result_if.valid && result_if.ready)
                check_result();
            result_if.ready <= !hold_results && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver stall, counted here so the sender keeps pushing meanwhile
    initial
    begin
        hold_results = 1'b0;
        wait (stall_request);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        store_register(idx, val);
    endtask

    task automatic program_gains(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                                 input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] i_hi,
                                 input logic [DATA_W-1:0] i_lo, input logic [DATA_W-1:0] c_hi,
                                 input logic [DATA_W-1:0] c_lo);
        write_register(REG_PROP_GAIN, kp);
        write_register(REG_INTEG_GAIN, ki);
        write_register(REG_DERIV_GAIN, kd);
        write_register(REG_INTEG_TERM_MAX, i_hi);
        write_register(REG_INTEG_TERM_MIN, i_lo);
        write_register(REG_COMMAND_MAX, c_hi);
        write_register(REG_COMMAND_MIN, c_lo);
    endtask

    // block is idle once nothing is queued, offered or outstanding
    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample_if.valid
               || expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic void queue_sample(input logic [DATA_W-1:0] err,
                                         input logic [DT_W-1:0] dt);
        sample_t s;
        s.error_sample = err;
        s.time_step    = dt;
        pending_samples.push_back(s);
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return '0;
        if (sel < 20)
            return S32_MAX;
        if (sel < 25)
            return S32_MIN;
        if (sel < 75)
            return $urandom_range(0, 32'h4_0000) - 32'h2_0000;  // within +-2.0
        return $urandom;
    endfunction

    // limits mostly small and on their own side, so clamps fire often;
    // the rest covers zero, extremes and crossed pairs
    function automatic logic [DATA_W-1:0] pick_limit(input bit upper);
        int unsigned sel;
        int unsigned mag;
        sel = $urandom_range(99);
        mag = $urandom_range(0, 32'h10_0000);
        if (sel < 10)
            return '0;
        if (sel < 15)
            return S32_MAX;
        if (sel < 20)
            return S32_MIN;
        if (sel < 30)
            return $urandom;
        return upper ? mag : -mag;
    endfunction

    function automatic void queue_random_sample();
        int unsigned sel;
        logic [DATA_W-1:0] err;
        logic [DT_W-1:0]   dt;

        sel = $urandom_range(9);
        if (sel < 4)
            err = $urandom_range(0, 32'h6_0000) - 32'h3_0000;
        else if (sel < 6)
            err = $urandom_range(0, 32'h100_0000) - 32'h80_0000;
        else if (sel < 9)
            err = $urandom;
        else
            case ($urandom_range(2))
                0:       err = S32_MAX;
                1:       err = S32_MIN;
                default: err = '0;
            endcase

        sel = $urandom_range(19);
        if (sel == 0)
            dt = '0;
        else if (sel == 1)
            dt = '1;
        else if (sel < 4)
            dt = DT_W'($urandom);
        else if (sel < 12)
            dt = DT_W'($urandom_range(1, 32'h2_0000));
        else
            dt = DT_W'($urandom_range(32'h100, 32'h4000));  // short steps, steep slopes
        queue_sample(err, dt);
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.index           = '0;
        cfg_if.data            = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // nominal tuning: kp 1.0, ki 0.5, kd 0.25, term +-10, command +-100
        program_gains(32'h1_0000, 32'h8000, 32'h4000, 32'h0A_0000, -32'sh0A_0000,
                      32'h64_0000, -32'sh64_0000);
        write_register(REG_UNMAPPED, 32'hDEAD_BEEF);
        queue_sample('0, '0);                  // zero step rejected
        queue_sample(S32_MAX, '1);
        queue_sample(S32_MIN, '1);
        queue_sample(S32_MIN, 31'd1);          // derivative saturates
        queue_sample(S32_MAX, 31'd1);
        queue_sample(32'h1234_5678, '0);       // rejected, last error kept
        queue_sample('0, 31'h1_0000);
        queue_sample(-32'sh8000, 31'h1_0000);  // floor of a negative product
        wait_drained();

        // extreme gains, wide term limits, both command limits disabled
        program_gains(S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MIN, '0, '0);
        queue_sample(S32_MAX, '1);
        queue_sample(S32_MIN, '1);
        queue_sample(S32_MAX, 31'd1);
        queue_sample(32'd1, 31'd1);
        wait_drained();

        // zero integral gain with zero above the term max: flagged, integral kept
        program_gains(32'h1_0000, '0, '0, -32'sh5_0000, -32'sh0A_0000,
                      32'h3_0000, -32'sh3_0000);
        queue_sample(32'h1_0000, 31'h1_0000);
        queue_sample(S32_MAX, 31'h1_0000);     // command hits the max
        queue_sample(S32_MIN, 31'h1_0000);     // command hits the min
        wait_drained();

        // crossed term and command limits: min wins the command, max test first for the term
        program_gains(32'hFFFF_0000, 32'h1_0000, S32_MAX, -32'sh0A_0000, 32'h0A_0000,
                      -32'sh1_0000, 32'h1_0000);
        queue_sample(32'h4_0000, 31'h8000);
        queue_sample(-32'sh4_0000, 31'h2_0000);
        queue_sample('0, '1);
        queue_sample(S32_MAX, '1);
        wait_drained();

        // random blocks, each under fresh register settings
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            if (blk == 2)
            begin
                tx_idle_pct = 51;
                rx_idle_pct = 24;
            end
            else if (blk == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            program_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit(1'b1),
                          pick_limit(1'b0), pick_limit(1'b1), pick_limit(1'b0));
            for (int n = 0; n < BLOCK_ITEMS; n++)
                queue_random_sample();
            // starve the result side so the pipeline backs up into the input
            if (blk == 1)
                stall_request <= 1'b1;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, many times the slowest legal run
    initial
    begin
        #(20_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
